@@ rtl/i2cadc_pkg.sv @@
package i2cadc_pkg;

  localparam int LEVEL_BITS        = 16;
  localparam int SETTABLE_CHANNELS = 11;
  localparam int CH_BITS           = 4;
  localparam int CH_IDX_BITS       = (SETTABLE_CHANNELS > 1) ? $clog2(SETTABLE_CHANNELS) : 1;
  localparam int QUO_BITS          = 8;
  localparam int CFG_IDX_BITS      = 2;

  localparam logic [CH_BITS-1:0] REF_CHANNEL = 4'd11;

  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_READ  = 3'd2;
  localparam logic [2:0] OP_STOP  = 3'd3;
  localparam logic [2:0] OP_LEVEL = 3'd4;

  localparam logic [CFG_IDX_BITS-1:0] REG_DEVICE_ADDRESS  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_EXTERNAL_REF_MV = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SUPPLY_MV       = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_INTERNAL_REF_MV = 2'd3;

  // Outcome of one bus event, handed from the scan control to the sequencer
  typedef struct packed {
    logic                  ack;
    logic                  conv;
    logic [LEVEL_BITS-1:0] level;
    logic [LEVEL_BITS-1:0] ref_mv;
  } scan_res_t;

endpackage

@@ rtl/i2cadc_div.sv @@
module i2cadc_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [i2cadc_pkg::LEVEL_BITS-1:0]   level,
  input  logic [i2cadc_pkg::LEVEL_BITS-1:0]   ref_mv,
  output logic                                done,
  output logic [i2cadc_pkg::QUO_BITS-1:0]     quo
);
  import i2cadc_pkg::*;

  localparam int CNT_BITS = $clog2(QUO_BITS);

  logic                  busy;
  logic                  checking;
  logic [LEVEL_BITS:0]   rem;
  logic [LEVEL_BITS-1:0] den;
  logic [CNT_BITS-1:0]   cnt;
  logic [LEVEL_BITS:0]   rem_shift;
  logic [LEVEL_BITS:0]   rem_diff;
  logic                  rem_ge;

  assign rem_shift = {rem[LEVEL_BITS-1:0], 1'b0};
  assign rem_diff  = rem_shift - {1'b0, den};
  assign rem_ge    = rem_shift >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      checking <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        checking <= 1'b1;
      end else if (busy) begin
        if (checking) begin
          checking <= 1'b0;
          // zero reference or quotient past full scale: finish at once
          if (den == '0 || rem[LEVEL_BITS-1:0] >= den) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end else if (cnt == CNT_BITS'(QUO_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, level};
      den <= ref_mv;
      quo <= '0;
      cnt <= '0;
    end else if (busy) begin
      if (checking) begin
        if (den == '0) begin
          quo <= '0;
        end else if (rem[LEVEL_BITS-1:0] >= den) begin
          quo <= '1;
        end
      end else begin
        if (rem_ge) begin
          rem <= rem_diff;
          quo <= {quo[QUO_BITS-2:0], 1'b1};
        end else begin
          rem <= rem_shift;
          quo <= {quo[QUO_BITS-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

@@ rtl/i2cadc_scan.sv @@
module i2cadc_scan (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  exec,
  input  logic [2:0]                            op,
  input  logic [6:0]                            addr,
  input  logic                                  rd,
  input  logic [7:0]                            byte_in,
  input  logic [i2cadc_pkg::CH_BITS-1:0]        ch,
  input  logic [i2cadc_pkg::LEVEL_BITS-1:0]     mv,
  input  logic                                  cfg_write,
  input  logic [i2cadc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [15:0]                           cfg_data,
  output i2cadc_pkg::scan_res_t                 res
);
  import i2cadc_pkg::*;

  logic [6:0]            device_address;
  logic [LEVEL_BITS-1:0] external_ref_mv;
  logic [LEVEL_BITS-1:0] supply_mv;
  logic [LEVEL_BITS-1:0] internal_ref_mv;

  logic                  selected;
  logic                  reading;
  logic [2:0]            ref_select;
  logic [1:0]            scan_mode;
  logic [CH_BITS-1:0]    chan_select;
  logic [1:0]            latched_scan_mode;
  logic [CH_BITS-1:0]    latched_last_chan;
  logic                  latched_skip_ref;
  logic [CH_BITS-1:0]    scan_position;
  logic [LEVEL_BITS-1:0] levels [SETTABLE_CHANNELS];

  logic                  pin_is_ref;
  logic [LEVEL_BITS-1:0] cur_level;
  logic [CH_BITS-1:0]    step1;
  logic [CH_BITS-1:0]    step2;
  logic [CH_BITS-1:0]    pos_next;

  assign pin_is_ref = ref_select[1];

  always_comb begin
    if (scan_position == REF_CHANNEL) begin
      cur_level = pin_is_ref ? '0 : external_ref_mv;
    end else if (scan_position < CH_BITS'(SETTABLE_CHANNELS)) begin
      cur_level = levels[scan_position[CH_IDX_BITS-1:0]];
    end else begin
      cur_level = '0;
    end
  end

  // in mode 0 wrap at the last channel and skip the ref pin if asked
  always_comb begin
    step1 = (scan_position >= latched_last_chan) ? '0 : scan_position + 1'b1;
    step2 = (step1 >= latched_last_chan) ? '0 : step1 + 1'b1;
    if (latched_scan_mode != 2'd0) begin
      pos_next = latched_last_chan;
    end else if (step1 == REF_CHANNEL && latched_skip_ref) begin
      pos_next = step2;
    end else begin
      pos_next = step1;
    end
  end

  always_comb begin
    res.ack    = 1'b0;
    res.conv   = 1'b0;
    res.level  = cur_level;
    if (ref_select[2]) begin
      res.ref_mv = internal_ref_mv;
    end else if (ref_select[1]) begin
      res.ref_mv = external_ref_mv;
    end else begin
      res.ref_mv = supply_mv;
    end
    case (op)
      OP_START: res.ack  = (addr == device_address);
      OP_WRITE: res.ack  = selected;
      OP_READ:  res.conv = selected && reading;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address  <= 7'd100;
      external_ref_mv <= '0;
      supply_mv       <= LEVEL_BITS'(3300);
      internal_ref_mv <= LEVEL_BITS'(2048);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DEVICE_ADDRESS:  device_address  <= cfg_data[6:0];
        REG_EXTERNAL_REF_MV: external_ref_mv <= cfg_data[LEVEL_BITS-1:0];
        REG_SUPPLY_MV:       supply_mv       <= cfg_data[LEVEL_BITS-1:0];
        REG_INTERNAL_REF_MV: internal_ref_mv <= cfg_data[LEVEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      selected          <= 1'b0;
      reading           <= 1'b0;
      ref_select        <= '0;
      scan_mode         <= '0;
      chan_select       <= '0;
      latched_scan_mode <= '0;
      latched_last_chan <= '0;
      latched_skip_ref  <= 1'b0;
      scan_position     <= '0;
      for (int i = 0; i < SETTABLE_CHANNELS; i++) begin
        levels[i] <= '0;
      end
    end else if (exec) begin
      case (op)
        OP_START: begin
          if (addr != device_address) begin
            selected <= 1'b0;
          end else begin
            selected <= 1'b1;
            reading  <= rd;
            if (rd) begin
              latched_scan_mode <= scan_mode;
              latched_last_chan <= chan_select;
              latched_skip_ref  <= pin_is_ref;
              scan_position     <= (scan_mode != 2'd0) ? chan_select : '0;
            end
          end
        end
        OP_WRITE: begin
          if (selected) begin
            if (byte_in[7]) begin
              ref_select <= byte_in[6:4];
            end else begin
              scan_mode   <= byte_in[6:5];
              chan_select <= byte_in[4:1];
            end
          end
        end
        OP_READ: begin
          if (selected && reading) begin
            scan_position <= pos_next;
          end
        end
        OP_STOP: selected <= 1'b0;
        OP_LEVEL: begin
          if (ch < CH_BITS'(SETTABLE_CHANNELS)) begin
            levels[ch[CH_IDX_BITS-1:0]] <= mv;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/i2c_adc_slave_scan_model.sv @@
// Two-wire 8-bit ADC slave, modeled at the level of bus events.
// Input channel (in_valid / in_stall): one bus event per item -- start,
// byte write, byte read, stop, or a channel level update. Output channel
// (out_valid / out_stall): exactly one result item per input item, carrying
// ack and read_data.
// Configuration: cfg_write with cfg_index / cfg_data sets the device address
// and the three reference levels; write only while no item is in flight.
// Flow: an event that does not convert passes through the execute and done
// states before it is loaded into the output register. A converting read
// runs the bit-serial divider, one quotient bit per cycle after a range
// check that can end it early, and then goes through the done state.
// Throughput: one item at a time; the next item is accepted the cycle after
// the previous result has been loaded into the output register.
// A stalled result holds in the output register while the block already
// takes and works on the next item; that item then waits for the register.
// Reset (rst, synchronous) deselects the part, clears the scan state and the
// channel levels, and restores the configuration defaults.
module i2c_adc_slave_scan_model (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [2:0]                            opcode,
  input  logic [6:0]                            bus_address,
  input  logic                                  read_flag,
  input  logic [7:0]                            data_byte,
  input  logic [i2cadc_pkg::CH_BITS-1:0]        channel_index,
  input  logic [i2cadc_pkg::LEVEL_BITS-1:0]     level_mv,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  ack,
  output logic [7:0]                            read_data,
  input  logic                                  cfg_write,
  input  logic [i2cadc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [15:0]                           cfg_data
);
  import i2cadc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_CONV = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]            state;
  logic [2:0]            op_q;
  logic [6:0]            addr_q;
  logic                  rd_q;
  logic [7:0]            byte_q;
  logic [CH_BITS-1:0]    ch_q;
  logic [LEVEL_BITS-1:0] mv_q;
  logic                  pend_ack;
  logic [QUO_BITS-1:0]   pend_data;

  scan_res_t             res;
  logic                  div_start;
  logic                  div_done;
  logic [QUO_BITS-1:0]   div_quo;
  logic                  in_take;
  logic                  out_free;

  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign div_start = (state == S_EXEC) && res.conv;

  i2cadc_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .exec      (state == S_EXEC),
    .op        (op_q),
    .addr      (addr_q),
    .rd        (rd_q),
    .byte_in   (byte_q),
    .ch        (ch_q),
    .mv        (mv_q),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (res)
  );

  i2cadc_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .level  (res.level),
    .ref_mv (res.ref_mv),
    .done   (div_done),
    .quo    (div_quo)
  );

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_q   <= opcode;
      addr_q <= bus_address;
      rd_q   <= read_flag;
      byte_q <= data_byte;
      ch_q   <= channel_index;
      mv_q   <= level_mv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // load a finished result, else drop the one the receiver took
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= res.conv ? S_CONV : S_DONE;
        end
        S_CONV: begin
          if (div_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold the result until the output register is free
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      pend_ack  <= res.ack;
      pend_data <= '0;
    end else if (state == S_CONV && div_done) begin
      pend_data <= div_quo;
    end
    if (state == S_DONE && out_free) begin
      ack       <= pend_ack;
      read_data <= pend_data;
    end
  end

  a_take_exec: assert property (@(posedge clk) disable iff (rst)
    in_take |=> state == S_EXEC)
    else $error("accepted item did not enter execution");

  a_div_done_conv: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_CONV)
    else $error("divider finished outside conversion");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> out_valid && state == S_IDLE)
    else $error("finished result not loaded");

  a_ack_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(ack && read_data != '0))
    else $error("result carries both ack and read data");

endmodule
